// ===== hw/rtl/slbc_pkg.sv =====
package slbc_pkg;

	localparam int DUTY_W  = 14;
	localparam int COUNT_W = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_CH  = 3;

	localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

	// Item kinds
	localparam logic [1:0] KIND_MODE = 2'd0;
	localparam logic [1:0] KIND_FAST = 2'd1;
	localparam logic [1:0] KIND_SLOW = 2'd2;

	// Mode flag positions
	localparam logic [2:0] MODE_DETECT  = 3'd0;
	localparam logic [2:0] MODE_START   = 3'd1;
	localparam logic [2:0] MODE_DOING   = 3'd2;
	localparam logic [2:0] MODE_END     = 3'd3;
	localparam logic [2:0] MODE_WARNING = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DETECT_LIMIT = 2'd2;

	// Ramp channels
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	localparam logic [DUTY_W-1:0]  RST_FULL_DUTY    = 14'd10000;
	localparam logic [DUTY_W-1:0]  RST_RAMP_STEP    = 14'd25;
	localparam logic [COUNT_W-1:0] RST_DETECT_LIMIT = 16'd100;

	typedef struct packed {
		logic [DUTY_W-1:0]  full_duty;
		logic [DUTY_W-1:0]  ramp_step;
		logic [COUNT_W-1:0] detect_limit;
	} slbc_cfg_t;

	typedef struct packed {
		logic              led1;
		logic              led2;
		logic              led3;
		logic [DUTY_W-1:0] red;
		logic [DUTY_W-1:0] green;
		logic [DUTY_W-1:0] blue;
	} slbc_result_t;

endpackage

// ===== hw/rtl/slbc_ramp.sv =====
module slbc_ramp (
	input  logic [slbc_pkg::DUTY_W-1:0] duty,
	input  logic                        falling,
	input  slbc_pkg::slbc_cfg_t         cfg,
	output logic [slbc_pkg::DUTY_W-1:0] duty_next,
	output logic                        falling_next
);
	import slbc_pkg::*;

	logic [DUTY_W:0]   sum;
	logic [DUTY_W-1:0] risen;
	logic              turn;

	always_comb begin
		sum = {1'b0, duty} + {1'b0, cfg.ramp_step};
		if (falling) begin
			risen = duty;
		end else if (sum[DUTY_W]) begin
			risen = DUTY_MAX;
		end else begin
			risen = sum[DUTY_W-1:0];
		end
		turn = falling || (risen >= cfg.full_duty);
		if (turn) begin
			// fall saturates at zero
			duty_next = (risen > cfg.ramp_step) ? risen - cfg.ramp_step : '0;
		end else begin
			duty_next = risen;
		end
		falling_next = turn && (duty_next != '0);
	end

endmodule

// ===== hw/rtl/slbc_core.sv =====
module slbc_core #(
	parameter int NUM_MODES = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic [1:0]             kind,
	input  logic [2:0]             mode,
	input  logic                   enable,
	input  slbc_pkg::slbc_cfg_t    cfg,
	output slbc_pkg::slbc_result_t res_next
);
	import slbc_pkg::*;

	logic [NUM_MODES-1:0] flags_q, flags_d, mode_hot, lowest;
	logic [7:0]           lowest8;
	logic [DUTY_W-1:0]    duty_q [NUM_CH];
	logic [DUTY_W-1:0]    duty_d [NUM_CH];
	logic                 falling_q [NUM_CH];
	logic                 falling_d [NUM_CH];
	logic [NUM_CH-1:0]    adv;
	logic [COUNT_W-1:0]   count_q, count_d;
	logic [2:0]           leds_q, leds_d;
	logic [DUTY_W-1:0]    ramp_duty [NUM_CH];
	logic                 ramp_fall [NUM_CH];
	logic                 is_fast, is_slow, any_flag;

	always_comb begin
		for (int i = 0; i < NUM_MODES; i++) begin
			mode_hot[i] = (mode == 3'(i));
		end
	end

	assign is_fast  = (kind == KIND_FAST);
	assign is_slow  = (kind == KIND_SLOW);
	assign any_flag = |flags_q;
	assign lowest   = flags_q & (~flags_q + NUM_MODES'(1));
	assign lowest8  = 8'(lowest);

	assign adv[CH_RED]   = is_slow || (is_fast && lowest8[MODE_WARNING]);
	assign adv[CH_GREEN] = is_slow || (is_fast && lowest8[MODE_START]);
	assign adv[CH_BLUE]  = is_slow || (is_fast && lowest8[MODE_DOING]);

	for (genvar c = 0; c < NUM_CH; c++) begin : g_ramp
		slbc_ramp u_ramp (
			.duty         (duty_q[c]),
			.falling      (falling_q[c]),
			.cfg          (cfg),
			.duty_next    (ramp_duty[c]),
			.falling_next (ramp_fall[c])
		);
		assign duty_d[c]    = adv[c] ? ramp_duty[c] : duty_q[c];
		assign falling_d[c] = adv[c] ? ramp_fall[c] : falling_q[c];
	end

	always_comb begin
		flags_d = flags_q;
		count_d = count_q;
		leds_d  = leds_q;
		if (kind == KIND_MODE) begin
			// a write beyond the mode count matches no bit
			if (enable) begin
				flags_d = flags_q | mode_hot;
			end else begin
				flags_d = flags_q & ~mode_hot;
			end
		end else if (is_fast) begin
			if (!any_flag) begin
				leds_d = '0;
			end else if (lowest8[MODE_DETECT]) begin
				leds_d[0] = ~leds_q[0];
				count_d   = count_q + COUNT_W'(1);
				if (count_q > cfg.detect_limit) begin
					count_d   = '0;
					leds_d[0] = 1'b0;
					leds_d[1] = 1'b1;
				end
			end else if (lowest8[MODE_END]) begin
				leds_d[2] = ~leds_q[2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			count_q <= '0;
			leds_q  <= '0;
			for (int c = 0; c < NUM_CH; c++) begin
				duty_q[c]    <= '0;
				falling_q[c] <= 1'b0;
			end
		end else if (fire) begin
			flags_q <= flags_d;
			count_q <= count_d;
			leds_q  <= leds_d;
			for (int c = 0; c < NUM_CH; c++) begin
				duty_q[c]    <= duty_d[c];
				falling_q[c] <= falling_d[c];
			end
		end
	end

	assign res_next.led1  = leds_d[0];
	assign res_next.led2  = leds_d[1];
	assign res_next.led3  = leds_d[2];
	assign res_next.red   = duty_d[CH_RED];
	assign res_next.green = duty_d[CH_GREEN];
	assign res_next.blue  = duty_d[CH_BLUE];

endmodule

// ===== hw/rtl/status_led_breathing_controller.sv =====
// Channel  Handshake             Beat payload
// in       in_valid / in_ready   kind, mode, enable
// out      out_valid / out_ready led1..3_level, red/green/blue_duty
// cfg      cfg_write_en          cfg_index, cfg_data
//
// One beat per cycle sustained. The input register feeds one pass of flag,
// counter and ramp logic straight into the result register. Input stalls
// only when both registers are full and out_ready is low. Reset clears
// flags, ramps, counter and LEDs and loads the register defaults; no
// clearing pass is needed.
module status_led_breathing_controller #(
	parameter int NUM_MODES = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [2:0]                     mode,
	input  logic                           enable,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           led1_level,
	output logic                           led2_level,
	output logic                           led3_level,
	output logic [slbc_pkg::DUTY_W-1:0]    red_duty,
	output logic [slbc_pkg::DUTY_W-1:0]    green_duty,
	output logic [slbc_pkg::DUTY_W-1:0]    blue_duty,
	input  logic                           cfg_write_en,
	input  logic [slbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [slbc_pkg::CFG_W-1:0]     cfg_data
);
	import slbc_pkg::*;

	slbc_cfg_t    cfg_q;
	slbc_result_t res_q, res_next;
	logic         valid_s1, out_valid_q, fire;
	logic [1:0]   kind_s1;
	logic [2:0]   mode_s1;
	logic         enable_s1;

	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_duty    <= RST_FULL_DUTY;
			cfg_q.ramp_step    <= RST_RAMP_STEP;
			cfg_q.detect_limit <= RST_DETECT_LIMIT;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_FULL_DUTY:    cfg_q.full_duty    <= cfg_data[DUTY_W-1:0];
				CFG_RAMP_STEP:    cfg_q.ramp_step    <= cfg_data[DUTY_W-1:0];
				CFG_DETECT_LIMIT: cfg_q.detect_limit <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1   <= kind;
			mode_s1   <= mode;
			enable_s1 <= enable;
		end
		if (fire) begin
			res_q <= res_next;
		end
	end

	slbc_core #(
		.NUM_MODES (NUM_MODES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.kind     (kind_s1),
		.mode     (mode_s1),
		.enable   (enable_s1),
		.cfg      (cfg_q),
		.res_next (res_next)
	);

	assign out_valid  = out_valid_q;
	assign led1_level = res_q.led1;
	assign led2_level = res_q.led2;
	assign led3_level = res_q.led3;
	assign red_duty   = res_q.red;
	assign green_duty = res_q.green;
	assign blue_duty  = res_q.blue;

endmodule
